/* sv/base64_stream_codec_core_assert.svh */
// Assertion macros for the base64 stream codec core.
`ifndef BASE64_STREAM_CODEC_CORE_ASSERT_SVH
`define BASE64_STREAM_CODEC_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define B64SC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
`define B64SC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define B64SC_ASSERT(lbl, clk, rst, prop)
`define B64SC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* sv/b64sc_pkg.sv */
// Types, codes and alphabet mapping for the base64 stream codec.
`default_nettype none
package b64sc_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BADCHAR    = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  localparam int unsigned NumSlots = 4;
  localparam logic [2:0] AddrDirection = 3'd0;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v <= 6'd25) begin
      return w + 8'd65;
    end else if (v <= 6'd51) begin
      return w + 8'd71;
    end else if (v <= 6'd61) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end
    return 8'h2F;
  endfunction

  // {valid, sextet}
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'd65;
      return {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
      return {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
      return {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end
    return {1'b0, d[5:0]};
  endfunction

endpackage
`default_nettype wire

/* sv/base64_stream_codec_core.sv */
// Base64 stream codec core: byte-serial encode/decode with a result burst register.
// Latency: an item's first result is valid the cycle after its transfer.
// Throughput: one input per cycle while items give no result; a group's results
// (four encoding, three decoding) drain from the burst register one per cycle while
// m_tready is high. Reset clears direction (encode), the partial group and busy/remain.
`default_nettype none
`include "base64_stream_codec_core_assert.svh"
module base64_stream_codec_core
  import b64sc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic [1:0]       m_tuser,   // [1:0] status
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        direction;
  logic [23:0] group_bits;
  logic [23:0] group_bits_next;
  logic [1:0]  group_count;
  logic [1:0]  group_count_next;
  logic [7:0]  slot [NumSlots];
  logic [7:0]  slot_next [NumSlots];
  status_t     status;
  status_t     status_next;
  logic [1:0]  remain;
  logic [1:0]  remain_next;
  logic        busy;
  logic        emit;
  logic        in_xfer;
  logic        out_xfer;
  logic        cfg_wr;
  logic [6:0]  sx;
  logic [23:0] gb_enc;
  logic [23:0] gb_dec;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == AddrDirection[2]);
  assign prdata   = (paddr[2] == AddrDirection[2]) ? {31'd0, direction} : 32'd0;

  assign m_tvalid = busy;
  assign m_tdata  = slot[0];
  assign m_tuser  = status;
  assign m_tlast  = (remain == 2'd0);
  assign out_xfer = m_tvalid && m_tready;
  assign s_tready = !busy || (out_xfer && remain == 2'd0);
  assign in_xfer  = s_tvalid && s_tready;

  assign sx     = char_to_sextet(s_tdata);
  assign gb_enc = {group_bits[15:0], s_tdata};
  assign gb_dec = {group_bits[17:0], sx[5:0]};

  always_comb begin
    emit             = 1'b0;
    status_next      = ST_OK;
    remain_next      = 2'd0;
    group_bits_next  = group_bits;
    group_count_next = group_count;
    for (int i = 0; i < NumSlots; i++) begin
      slot_next[i] = 8'd0;
    end
    if (!direction) begin
      if (group_count == 2'd2) begin
        emit             = 1'b1;
        remain_next      = 2'd3;
        slot_next[0]     = sextet_to_char(gb_enc[23:18]);
        slot_next[1]     = sextet_to_char(gb_enc[17:12]);
        slot_next[2]     = sextet_to_char(gb_enc[11:6]);
        slot_next[3]     = sextet_to_char(gb_enc[5:0]);
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
      end else if (s_tlast) begin
        emit             = 1'b1;
        status_next      = ST_INCOMPLETE;
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
      end else begin
        group_bits_next  = gb_enc;
        group_count_next = group_count + 2'd1;
      end
    end else begin
      if (!sx[6]) begin
        emit             = 1'b1;
        status_next      = ST_BADCHAR;
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
      end else if (group_count == 2'd3) begin
        emit             = 1'b1;
        remain_next      = 2'd2;
        slot_next[0]     = gb_dec[23:16];
        slot_next[1]     = gb_dec[15:8];
        slot_next[2]     = gb_dec[7:0];
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
      end else if (s_tlast) begin
        emit             = 1'b1;
        status_next      = ST_INCOMPLETE;
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
      end else begin
        group_bits_next  = gb_dec;
        group_count_next = group_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      group_bits  <= 24'd0;
      group_count <= 2'd0;
    end else if (cfg_wr) begin
      direction   <= pwdata[0];
      group_bits  <= 24'd0;
      group_count <= 2'd0;
    end else if (in_xfer) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      remain <= 2'd0;
    end else if (in_xfer && emit) begin
      busy   <= 1'b1;
      remain <= remain_next;
    end else if (out_xfer) begin
      busy   <= (remain != 2'd0);
      remain <= remain - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      status <= status_next;
      for (int i = 0; i < NumSlots; i++) begin
        slot[i] <= slot_next[i];
      end
    end else if (out_xfer) begin
      for (int i = 0; i < NumSlots - 1; i++) begin
        slot[i] <= slot[i + 1];
      end
      slot[NumSlots - 1] <= 8'd0;
    end
  end

  `B64SC_ASSERT(a_enc_count_range, clk, rst, (!direction) |-> (group_count != 2'd3))
  `B64SC_ASSERT(a_ready_while_busy, clk, rst,
    (busy && s_tready) |-> (m_tready && remain == 2'd0))
  `B64SC_ASSERT(a_error_single, clk, rst, (busy && status != ST_OK) |-> (remain == 2'd0))
  `B64SC_ASSERT_NEXT(a_enc_burst, clk, rst,
    (in_xfer && !cfg_wr && !direction && group_count == 2'd2),
    (busy && remain == 2'd3 && status == ST_OK && group_count == 2'd0))
  `B64SC_ASSERT_NEXT(a_dec_burst, clk, rst,
    (in_xfer && !cfg_wr && direction && sx[6] && group_count == 2'd3),
    (busy && remain == 2'd2 && status == ST_OK && group_count == 2'd0))

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the base64 stream codec core: directed table, then random frames.
module tb_top
  import b64sc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] AddrUnused = 3'd4;
  localparam logic [2:0] UsePredictor = 3'd7;
  localparam int SettleCycles = 4;
  localparam int TailCycles = 10;
  localparam int LongHold = 64;
  localparam int RandPhases = 8;
  localparam int PhaseItems = 52;
  localparam int CycleLimit = 300000;
  localparam int NumRows = 27;
  localparam int NumLits = 16;

  typedef struct packed {
    logic [7:0] code;
    status_t    st;
    logic       fin;
  } b64_result_t;

  typedef struct packed {
    logic       is_cfg;
    logic [2:0] addr;
    logic [7:0] data;
    logic       fin;
    logic [2:0] lit_n;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  base64_stream_codec_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] in_byte
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] out_byte
    .m_tuser  (m_tuser),   // [1:0] status
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  string alphabet_s = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  int sextet_of [256];

  // codec state mirror
  logic        dec_mode = 1'b0;
  logic [23:0] acc_bits = 24'd0;
  logic [1:0]  acc_count = 2'd0;

  b64_result_t burst_q [$];
  b64_result_t expected_q [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          idling_on = 1'b1;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          rx_idle = 0;

  stim_row_t directed_rows [NumRows] = '{
    '{1'b0, 3'd0, 8'h00, 1'b0, 3'd0},
    '{1'b0, 3'd0, 8'h00, 1'b0, 3'd0},
    '{1'b0, 3'd0, 8'h00, 1'b0, 3'd4},
    '{1'b0, 3'd0, 8'hFF, 1'b0, 3'd0},
    '{1'b0, 3'd0, 8'hFF, 1'b0, 3'd0},
    '{1'b0, 3'd0, 8'hFF, 1'b1, 3'd4},
    '{1'b0, 3'd0, 8'h4D, 1'b1, 3'd1},
    '{1'b1, AddrDirection, 8'd1, 1'b0, 3'd0},
    '{1'b0, 3'd0, "A",   1'b0, 3'd0},
    '{1'b0, 3'd0, "A",   1'b0, 3'd0},
    '{1'b0, 3'd0, "/",   1'b0, 3'd0},
    '{1'b0, 3'd0, "/",   1'b0, 3'd3},
    '{1'b0, 3'd0, "=",   1'b0, 3'd1},
    '{1'b0, 3'd0, 8'h00, 1'b1, 3'd1},
    '{1'b0, 3'd0, 8'hFF, 1'b0, 3'd1},
    '{1'b0, 3'd0, "Z",   1'b0, 3'd0},
    '{1'b0, 3'd0, "z",   1'b1, 3'd1},
    '{1'b0, 3'd0, "0",   1'b0, UsePredictor},
    '{1'b0, 3'd0, "9",   1'b0, UsePredictor},
    '{1'b0, 3'd0, "+",   1'b0, UsePredictor},
    '{1'b1, AddrUnused, 8'd0, 1'b0, 3'd0},
    '{1'b0, 3'd0, "a",   1'b0, UsePredictor},
    '{1'b0, 3'd0, "g",   1'b0, UsePredictor},
    '{1'b1, AddrDirection, 8'd0, 1'b0, 3'd0},
    '{1'b0, 3'd0, "x",   1'b0, UsePredictor},
    '{1'b0, 3'd0, "y",   1'b0, UsePredictor},
    '{1'b0, 3'd0, "z",   1'b1, UsePredictor}
  };

  b64_result_t directed_lits [NumLits] = '{
    '{"A", ST_OK, 1'b0}, '{"A", ST_OK, 1'b0}, '{"A", ST_OK, 1'b0}, '{"A", ST_OK, 1'b1},
    '{"/", ST_OK, 1'b0}, '{"/", ST_OK, 1'b0}, '{"/", ST_OK, 1'b0}, '{"/", ST_OK, 1'b1},
    '{8'h00, ST_INCOMPLETE, 1'b1},
    '{8'h00, ST_OK, 1'b0}, '{8'h0F, ST_OK, 1'b0}, '{8'hFF, ST_OK, 1'b1},
    '{8'h00, ST_BADCHAR, 1'b1},
    '{8'h00, ST_BADCHAR, 1'b1},
    '{8'h00, ST_BADCHAR, 1'b1},
    '{8'h00, ST_INCOMPLETE, 1'b1}
  };

  initial begin
    foreach (sextet_of[i]) sextet_of[i] = -1;
    for (int i = 0; i < 64; i++) sextet_of[alphabet_s[i]] = i;
  end

  function automatic b64_result_t mk_res(input logic [7:0] code, input status_t st,
                                         input logic fin);
    b64_result_t r;
    r.code = code;
    r.st = st;
    r.fin = fin;
    return r;
  endfunction

  task automatic predict_item(input logic [7:0] b, input logic fin);
    int v;
    int k;
    burst_q.delete();
    if (!dec_mode) begin
      acc_bits = {acc_bits[15:0], b};
      if (acc_count == 2'd2) begin
        for (k = 0; k < 4; k++) begin
          burst_q.push_back(mk_res(alphabet_s[acc_bits[23 - 6 * k -: 6]], ST_OK, k == 3));
        end
        acc_bits = 24'd0;
        acc_count = 2'd0;
        return;
      end
    end else begin
      v = sextet_of[b];
      if (v < 0) begin
        acc_bits = 24'd0;
        acc_count = 2'd0;
        burst_q.push_back(mk_res(8'h00, ST_BADCHAR, 1'b1));
        return;
      end
      acc_bits = {acc_bits[17:0], 6'(v)};
      if (acc_count == 2'd3) begin
        burst_q.push_back(mk_res(acc_bits[23:16], ST_OK, 1'b0));
        burst_q.push_back(mk_res(acc_bits[15:8], ST_OK, 1'b0));
        burst_q.push_back(mk_res(acc_bits[7:0], ST_OK, 1'b1));
        acc_bits = 24'd0;
        acc_count = 2'd0;
        return;
      end
    end
    if (fin) begin
      acc_bits = 24'd0;
      acc_count = 2'd0;
      burst_q.push_back(mk_res(8'h00, ST_INCOMPLETE, 1'b1));
    end else begin
      acc_count = acc_count + 2'd1;
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic fin);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    predict_item(b, fin);
  endtask

  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrDirection) begin
      dec_mode = value[0];
      acc_bits = 24'd0;
      acc_count = 2'd0;
    end
    @(posedge clk);
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      rx_idle = LongHold;
    end else if (rx_idle == 0 && idling_on && $urandom_range(0, 5) == 0) begin
      rx_idle = $urandom_range(1, 5);
    end
    if (rx_idle != 0) begin
      m_tready <= 1'b0;
      rx_idle = rx_idle - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    b64_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transfer: out_byte %h status %0d out_last %0b",
               m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (m_tdata !== want.code) begin
          $error("out_byte: expected %h, got %h", want.code, m_tdata);
          fail_count++;
        end
        if (m_tuser !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_tuser);
          fail_count++;
        end
        if (m_tlast !== want.fin) begin
          $error("out_last: expected %0b, got %0b", want.fin, m_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("base64_stream_codec_core: mismatch");
      $finish;
    end
  end

  initial begin
    int lit_idx;
    int sent;
    int flen;
    int j;
    logic dir;
    logic [7:0] b;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    lit_idx = 0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        drain_block();
        write_reg(directed_rows[r].addr, 32'(directed_rows[r].data));
      end else begin
        send_item(directed_rows[r].data, directed_rows[r].fin);
        if (directed_rows[r].lit_n == UsePredictor) begin
          foreach (burst_q[k]) expected_q.push_back(burst_q[k]);
        end else begin
          for (j = 0; j < int'(directed_rows[r].lit_n); j++) begin
            expected_q.push_back(directed_lits[lit_idx]);
            lit_idx++;
          end
        end
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      drain_block();
      if (p < 2) dir = p[0];
      else dir = 1'($urandom_range(0, 1));
      write_reg(AddrDirection, {31'd0, dir});
      if ($urandom_range(0, 3) == 0) write_reg(AddrUnused, $urandom);
      idling_on = (p != RandPhases - 1);
      if (p == 2) hold_requests++;
      sent = 0;
      while (sent < PhaseItems) begin
        flen = $urandom_range(1, 16);
        if (dir) begin
          if ($urandom_range(0, 9) < 7) flen = (flen + 3) / 4 * 4;
        end else if ($urandom_range(0, 9) < 6) begin
          flen = (flen + 2) / 3 * 3;
        end
        for (j = 0; j < flen; j++) begin
          if (dir && $urandom_range(0, 19) != 0) b = alphabet_s[$urandom_range(0, 63)];
          else b = 8'($urandom_range(0, 255));
          send_item(b, j == flen - 1);
          foreach (burst_q[k]) expected_q.push_back(burst_q[k]);
          sent++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("base64_stream_codec_core: match");
    end else begin
      $display("base64_stream_codec_core: mismatch");
    end
    $finish;
  end

endmodule
